// ===== rtl/rtt_trk_pkg.sv =====
// Shared types and constants for the TCP round-trip-time tracker.
// Used by rtt_trk_ctrl, rtt_trk_dp and tcp_rtt_tracker; depends on nothing.
`default_nettype none

package rtt_trk_pkg;

	// request kinds
	localparam logic CMD_SEND = 1'b0;
	localparam logic CMD_ACK  = 1'b1;

	// result status codes
	localparam logic [2:0] ST_RECORDED  = 3'd0;
	localparam logic [2:0] ST_MEASURED  = 3'd1;
	localparam logic [2:0] ST_FIN       = 3'd2;
	localparam logic [2:0] ST_NOT_FOUND = 3'd3;
	localparam logic [2:0] ST_FULL      = 3'd4;
	localparam logic [2:0] ST_DUPLICATE = 3'd5;

	localparam logic [15:0] SEG_SIZE_RESET = 16'd1024;

	typedef struct packed {
		logic        command;
		logic [31:0] seq_or_ack;
		logic        syn_flag;
		logic        fin_flag;
		logic [31:0] now_ms;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] rtt_ms;
		logic [31:0] rtt_max_ms;
		logic [31:0] rtt_min_ms;
		logic [34:0] rtt_avg_x8;
	} out_item_t;

	// controller -> datapath
	typedef struct packed {
		logic load;    // capture the accepted request, clear scan flags
		logic clear;   // write an empty entry at the table address
		logic rd;      // read the entry at the table address
		logic finish;  // commit the request and load the result register
	} ctrl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic out_full;  // result register cannot take a new result now
	} dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/rtt_trk_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`default_nettype none

module rtt_trk_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/rtt_trk_ctrl.sv =====
// Sequencer for the RTT tracker: clearing pass, table scan, commit.
// Depends on rtt_trk_pkg.
`default_nettype none

module rtt_trk_ctrl #(
	parameter int TABLE_DEPTH = 64
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire rtt_trk_pkg::in_item_t          in_data,
	output rtt_trk_pkg::ctrl_cmd_t              cmd,
	input  wire rtt_trk_pkg::dp_status_t        sts,
	output logic [$clog2(TABLE_DEPTH)-1:0]      tbl_addr
);

	localparam int AW = $clog2(TABLE_DEPTH);

	localparam logic [2:0] S_CLEAR  = 3'd0;
	localparam logic [2:0] S_IDLE   = 3'd1;
	localparam logic [2:0] S_SCAN   = 3'd2;
	localparam logic [2:0] S_DRAIN  = 3'd3;
	localparam logic [2:0] S_FINISH = 3'd4;

	logic [2:0]    state_q, state_d;
	logic [AW-1:0] addr_q, addr_d;
	logic          last;
	logic          skip_scan;

	assign last      = (addr_q == AW'(TABLE_DEPTH - 1));
	assign skip_scan = (in_data.command == rtt_trk_pkg::CMD_ACK) && in_data.fin_flag;
	assign tbl_addr  = addr_q;

	always_comb begin
		state_d  = state_q;
		addr_d   = addr_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clear = 1'b1;
				addr_d    = last ? '0 : addr_q + AW'(1);
				if (last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				in_ready = 1'b1;
				addr_d   = '0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = skip_scan ? S_FINISH : S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.rd = 1'b1;
				addr_d = last ? '0 : addr_q + AW'(1);
				if (last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = S_FINISH;
			end
			S_FINISH: begin
				if (!sts.out_full) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_CLEAR;
				addr_d  = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			addr_q  <= '0;
		end else begin
			state_q <= state_d;
			addr_q  <= addr_d;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/rtt_trk_dp.sv =====
// Datapath of the RTT tracker: entry table, scan logic, statistics, result register.
// Depends on rtt_trk_pkg and rtt_trk_ram.
`default_nettype none

module rtt_trk_dp #(
	parameter int TABLE_DEPTH = 64
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire rtt_trk_pkg::ctrl_cmd_t            cmd,
	output rtt_trk_pkg::dp_status_t                sts,
	input  wire logic [$clog2(TABLE_DEPTH)-1:0]    tbl_addr,
	input  wire rtt_trk_pkg::in_item_t             in_data,
	input  wire logic                              cfg_wr_en,
	input  wire logic [15:0]                       cfg_wr_data,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output rtt_trk_pkg::out_item_t                 out_data
);

	localparam int AW = $clog2(TABLE_DEPTH);

	typedef struct packed {
		logic        vld;
		logic [31:0] key;
		logic [31:0] stamp;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	logic [15:0]            seg_size_q;
	rtt_trk_pkg::in_item_t  item_q;
	logic [31:0]            key_q;
	logic                   match_q;
	logic [31:0]            rtt_q;
	logic                   free_vld_q;
	logic [AW-1:0]          free_idx_q;
	logic                   rd_v_s1;
	logic [AW-1:0]          addr_s1;
	logic [31:0]            max_q, min_q;
	logic [34:0]            avg_q;
	logic                   out_valid_q;
	rtt_trk_pkg::out_item_t out_q;

	logic [31:0]  addend;
	logic         carry_in;
	logic [31:0]  key_next;
	entry_t       ent;
	logic [ENTRY_W-1:0] rd_word;
	logic         hit_now;
	logic [31:0]  key_dist;
	logic         purge_we;
	logic         send_we;
	logic         is_ack;
	logic         fin_ack;
	logic         stats_we;
	logic [2:0]   status_n;
	logic [31:0]  max_n, min_n, rtt_out;
	logic [34:0]  avg_n;
	logic [37:0]  avg_x7;
	logic [35:0]  avg_blend;
	logic         ram_we;
	logic [AW-1:0] ram_waddr;
	entry_t       ram_wentry;

	// expected acknowledgement number of a send, or the ack number itself
	always_comb begin
		addend   = '0;
		carry_in = 1'b0;
		if (in_data.command == rtt_trk_pkg::CMD_SEND) begin
			if (in_data.syn_flag) begin
				carry_in = 1'b1;
			end else begin
				addend   = {16'd0, seg_size_q};
				carry_in = in_data.fin_flag;
			end
		end
	end
	assign key_next = in_data.seq_or_ack + addend + {31'd0, carry_in};

	assign ent      = rd_word;
	assign is_ack   = (item_q.command == rtt_trk_pkg::CMD_ACK);
	assign fin_ack  = is_ack && item_q.fin_flag;
	assign hit_now  = rd_v_s1 && ent.vld && (ent.key == key_q);
	assign key_dist = key_q - ent.key;
	// drop entries at or before the ack in serial order
	assign purge_we = rd_v_s1 && is_ack && ent.vld && !key_dist[31];
	assign send_we  = cmd.finish && !is_ack && !match_q && free_vld_q;
	assign stats_we = cmd.finish && is_ack && !fin_ack && match_q;

	always_comb begin
		ram_we     = cmd.clear || purge_we || send_we;
		ram_waddr  = tbl_addr;
		ram_wentry = '0;
		if (purge_we) begin
			ram_waddr = addr_s1;
		end else if (send_we) begin
			ram_waddr  = free_idx_q;
			ram_wentry = '{vld: 1'b1, key: key_q, stamp: item_q.now_ms};
		end
	end

	rtt_trk_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk    (clk),
		.wr_en  (ram_we),
		.wr_addr(ram_waddr),
		.wr_data(ram_wentry),
		.rd_en  (cmd.rd),
		.rd_addr(tbl_addr),
		.rd_data(rd_word)
	);

	// statistics after this request
	assign avg_x7    = {avg_q, 3'b000} - {3'b000, avg_q};
	assign avg_blend = {1'b0, avg_x7[37:3]} + {4'd0, rtt_q};

	always_comb begin
		max_n = max_q;
		min_n = min_q;
		avg_n = avg_q;
		if (stats_we) begin
			if (rtt_q > max_q) begin
				max_n = rtt_q;
			end
			if (min_q == '0 || rtt_q < min_q) begin
				min_n = rtt_q;
			end
			avg_n = (avg_q == '0) ? {rtt_q, 3'b000} : avg_blend[34:0];
		end
	end

	always_comb begin
		rtt_out = '0;
		priority if (fin_ack) begin
			status_n = rtt_trk_pkg::ST_FIN;
		end else if (!is_ack && match_q) begin
			status_n = rtt_trk_pkg::ST_DUPLICATE;
		end else if (!is_ack && !free_vld_q) begin
			status_n = rtt_trk_pkg::ST_FULL;
		end else if (!is_ack) begin
			status_n = rtt_trk_pkg::ST_RECORDED;
		end else if (match_q) begin
			status_n = rtt_trk_pkg::ST_MEASURED;
			rtt_out  = rtt_q;
		end else begin
			status_n = rtt_trk_pkg::ST_NOT_FOUND;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_size_q  <= rtt_trk_pkg::SEG_SIZE_RESET;
			rd_v_s1     <= 1'b0;
			match_q     <= 1'b0;
			free_vld_q  <= 1'b0;
			max_q       <= '0;
			min_q       <= '0;
			avg_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				seg_size_q <= cfg_wr_data;
			end
			rd_v_s1 <= cmd.rd;
			if (cmd.load) begin
				match_q    <= 1'b0;
				free_vld_q <= 1'b0;
			end else begin
				if (hit_now) begin
					match_q <= 1'b1;
				end
				if (rd_v_s1 && !ent.vld && !free_vld_q) begin
					free_vld_q <= 1'b1;
				end
			end
			max_q <= max_n;
			min_q <= min_n;
			avg_q <= avg_n;
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= tbl_addr;
		if (cmd.load) begin
			item_q <= in_data;
			key_q  <= key_next;
		end
		if (hit_now && !match_q) begin
			rtt_q <= item_q.now_ms - ent.stamp;
		end
		if (rd_v_s1 && !ent.vld && !free_vld_q && !cmd.load) begin
			free_idx_q <= addr_s1;
		end
		if (cmd.finish) begin
			out_q <= '{status: status_n, rtt_ms: rtt_out, rtt_max_ms: max_n,
				rtt_min_ms: min_n, rtt_avg_x8: avg_n};
		end
	end

	assign sts.out_full = out_valid_q && !out_ready;
	assign out_valid    = out_valid_q;
	assign out_data     = out_q;

	a_one_writer: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.clear, purge_we, send_we}))
		else $error("table written from two sources at once");

	a_rtt_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.status == rtt_trk_pkg::ST_MEASURED |->
		out_q.rtt_ms <= out_q.rtt_max_ms && out_q.rtt_min_ms <= out_q.rtt_ms)
		else $error("measured rtt outside min/max");

	a_rtt_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.status != rtt_trk_pkg::ST_MEASURED |->
		out_q.rtt_ms == '0)
		else $error("rtt reported without a measurement");

	a_stats_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!stats_we |=> $stable(max_q) && $stable(min_q) && $stable(avg_q))
		else $error("statistics changed without a measurement");

endmodule

`default_nettype wire

// ===== rtl/tcp_rtt_tracker.sv =====
// Top level of the TCP round-trip-time tracker.
// Depends on rtt_trk_pkg, rtt_trk_ctrl and rtt_trk_dp.
`default_nettype none

// Tracks the round-trip time of one TCP connection. A send request stores
// now_ms under the acknowledgement number it expects (seq + 1 for SYN,
// seq + segment_size + 1 for FIN, seq + segment_size otherwise) in a table of
// TABLE_DEPTH entries held in one RAM. A non-FIN acknowledgement looks up its
// exact key, measures rtt = now_ms - stored time, updates max, min (zero means
// unset) and an 7/8 : 1/8 smoothed average kept times eight, then drops every
// entry at or before the ack in serial order. Every request gives exactly one
// result carrying the status and the statistics after that request.
// Sequencing: one request is in flight at a time. A send or non-FIN ack reads
// every entry, one RAM read per entry through the single read port, then
// drains the registered read and commits, waiting while the result register
// is full; a FIN ack skips the scan and goes to commit. The result register
// lets the next request be accepted while a result waits to be taken. After
// reset a clearing pass empties the table, with in_ready low; segment_size
// writes are taken at any time and must only be issued while the block is idle.

module tcp_rtt_tracker #(
	parameter int TABLE_DEPTH = 64
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire rtt_trk_pkg::in_item_t  in_data,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output rtt_trk_pkg::out_item_t      out_data,
	input  wire logic                   cfg_wr_en,
	input  wire logic [15:0]            cfg_wr_data
);

	localparam int AW = $clog2(TABLE_DEPTH);

	rtt_trk_pkg::ctrl_cmd_t  cmd;
	rtt_trk_pkg::dp_status_t sts;
	logic [AW-1:0]           tbl_addr;

	// sequencer: clear pass, scan addresses, commit timing
	rtt_trk_ctrl #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data (in_data),
		.cmd     (cmd),
		.sts     (sts),
		.tbl_addr(tbl_addr)
	);

	// table, matching, purge, statistics and result register
	rtt_trk_dp #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.tbl_addr   (tbl_addr),
		.in_data    (in_data),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

endmodule

`default_nettype wire

// ===== sim/tcp_rtt_tracker_tb.sv =====
// Self-checking testbench for the TCP round-trip-time tracker.
// Depends on rtl/rtt_trk_pkg.sv and rtl/tcp_rtt_tracker.sv; reads no files.
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TBL_DEPTH    = 64;
	localparam int CLK_PERIOD   = 10;
	localparam int NUM_PHASES   = 8;
	localparam int PHASE_ITEMS  = 55;
	// A send or non-FIN ack walks the whole table, so the drain wait covers one
	// full scan plus the drain of the registered read and the commit.
	localparam int SCAN_CYCLES  = TBL_DEPTH + 3;
	localparam int RUN_LIMIT    = 500000;
	localparam int REPORT_LIMIT = 10;

	// One row of the directed table. Rows with typed_in set carry an expected
	// result that is obvious by inspection; all others go to the predictor.
	typedef struct {
		rtt_trk_pkg::in_item_t  req;
		logic                   typed_in;
		rtt_trk_pkg::out_item_t want;
	} dir_row_t;

	logic                   clk;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_ready;
	rtt_trk_pkg::in_item_t  in_data;
	logic                   out_valid;
	logic                   out_ready;
	rtt_trk_pkg::out_item_t out_data;
	logic                   cfg_wr_en;
	logic [15:0]            cfg_wr_data;

	tcp_rtt_tracker #(
		.TABLE_DEPTH(TBL_DEPTH)
	) uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	// ------------------------------------------------------------------
	// Predictor state: a private copy of the key table, the statistics and
	// the segment size register.
	// ------------------------------------------------------------------
	logic        tbl_live [TBL_DEPTH];
	logic [31:0] tbl_key  [TBL_DEPTH];
	logic [31:0] tbl_sent [TBL_DEPTH];
	logic [15:0] seg_size;
	logic [31:0] hi_rtt;
	logic [31:0] lo_rtt;
	logic [34:0] avg_x8;

	rtt_trk_pkg::out_item_t rtt_expect_q [$];
	dir_row_t    dir_rows [$];
	int          err_count;
	int          cycle_cnt;
	logic        send_idle;
	logic        recv_idle;
	int          stall_left;

	// Connection state used to build well-formed traffic.
	logic [31:0]           flow_seq;
	logic [31:0]           flow_now;
	rtt_trk_pkg::in_item_t last_send;

	// Apply one request to the predictor and return the result it must give.
	function automatic rtt_trk_pkg::out_item_t predict_rtt(input rtt_trk_pkg::in_item_t req);
		rtt_trk_pkg::out_item_t res;
		logic [31:0] key;
		logic [31:0] rtt;
		logic [31:0] lag;
		logic [37:0] prod;
		logic        dup;
		logic        hit;
		int          slot;
		int          i;
		res  = '0;
		rtt  = '0;
		if (req.command == rtt_trk_pkg::CMD_SEND) begin
			// SYN takes priority over FIN when both are set
			if (req.syn_flag)
				key = req.seq_or_ack + 32'd1;
			else if (req.fin_flag)
				key = req.seq_or_ack + {16'd0, seg_size} + 32'd1;
			else
				key = req.seq_or_ack + {16'd0, seg_size};
			dup  = 1'b0;
			slot = -1;
			for (i = 0; i < TBL_DEPTH; i++) begin
				if (tbl_live[i]) begin
					if (tbl_key[i] == key)
						dup = 1'b1;
				end else if (slot < 0) begin
					slot = i;
				end
			end
			if (dup) begin
				res.status = rtt_trk_pkg::ST_DUPLICATE;
			end else if (slot < 0) begin
				res.status = rtt_trk_pkg::ST_FULL;
			end else begin
				tbl_live[slot] = 1'b1;
				tbl_key[slot]  = key;
				tbl_sent[slot] = req.now_ms;
				res.status     = rtt_trk_pkg::ST_RECORDED;
			end
		end else if (req.fin_flag) begin
			// FIN on an ack is reported and otherwise ignored
			res.status = rtt_trk_pkg::ST_FIN;
		end else begin
			res.status = rtt_trk_pkg::ST_NOT_FOUND;
			hit = 1'b0;
			for (i = 0; i < TBL_DEPTH; i++) begin
				if (!hit && tbl_live[i] && tbl_key[i] == req.seq_or_ack) begin
					hit        = 1'b1;
					rtt        = req.now_ms - tbl_sent[i];
					res.status = rtt_trk_pkg::ST_MEASURED;
				end
			end
			if (hit) begin
				if (rtt > hi_rtt)
					hi_rtt = rtt;
				// zero means unset, so a zero rtt leaves the minimum reloadable
				if (lo_rtt == 32'd0 || rtt < lo_rtt)
					lo_rtt = rtt;
				if (avg_x8 == 35'd0) begin
					avg_x8 = {rtt, 3'b000};
				end else begin
					prod   = {3'b000, avg_x8} * 38'd7;
					avg_x8 = prod[37:3] + {3'b000, rtt};
				end
			end
			// drop everything at or before the ack in serial order
			for (i = 0; i < TBL_DEPTH; i++) begin
				lag = req.seq_or_ack - tbl_key[i];
				if (tbl_live[i] && !lag[31])
					tbl_live[i] = 1'b0;
			end
		end
		res.rtt_ms     = rtt;
		res.rtt_max_ms = hi_rtt;
		res.rtt_min_ms = lo_rtt;
		res.rtt_avg_x8 = avg_x8;
		return res;
	endfunction

	function automatic rtt_trk_pkg::in_item_t mk_req(input logic cmd, input logic [31:0] num,
			input logic syn, input logic fin, input logic [31:0] now);
		rtt_trk_pkg::in_item_t r;
		r.command    = cmd;
		r.seq_or_ack = num;
		r.syn_flag   = syn;
		r.fin_flag   = fin;
		r.now_ms     = now;
		return r;
	endfunction

	function automatic rtt_trk_pkg::out_item_t mk_res(input logic [2:0] st,
			input logic [31:0] rtt, input logic [31:0] hi, input logic [31:0] lo,
			input logic [34:0] avg);
		rtt_trk_pkg::out_item_t r;
		r.status     = st;
		r.rtt_ms     = rtt;
		r.rtt_max_ms = hi;
		r.rtt_min_ms = lo;
		r.rtt_avg_x8 = avg;
		return r;
	endfunction

	task automatic add_row(input rtt_trk_pkg::in_item_t req, input logic typed_in,
			input rtt_trk_pkg::out_item_t want);
		dir_row_t row;
		row.req      = req;
		row.typed_in = typed_in;
		row.want     = want;
		dir_rows.push_back(row);
	endtask

	// Next segment of the connection: advance the sequence number by the
	// segment size (plus one for SYN/FIN) and move the clock forward a little.
	function automatic rtt_trk_pkg::in_item_t make_flow_send();
		rtt_trk_pkg::in_item_t r;
		r.command    = rtt_trk_pkg::CMD_SEND;
		r.seq_or_ack = flow_seq;
		r.syn_flag   = ($urandom_range(0, 19) == 0);
		r.fin_flag   = ($urandom_range(0, 9) == 0);
		r.now_ms     = flow_now;
		flow_seq  = flow_seq + {16'd0, seg_size} + ((r.syn_flag || r.fin_flag) ? 32'd1 : 32'd0);
		flow_now  = flow_now + $urandom_range(0, 20);
		last_send = r;
		return r;
	endfunction

	// Mostly a live connection: sends and acks that hit an outstanding key.
	// The rest is noise: FIN acks, stray acks, resends and random sends.
	function automatic rtt_trk_pkg::in_item_t make_random_req();
		rtt_trk_pkg::in_item_t r;
		logic [31:0] live_keys [$];
		logic [31:0] lat;
		int unsigned pick;
		int          i;
		pick = $urandom_range(0, 99);
		for (i = 0; i < TBL_DEPTH; i++)
			if (tbl_live[i])
				live_keys.push_back(tbl_key[i]);
		if (pick < 40 || (pick < 75 && live_keys.size() == 0)) begin
			r = make_flow_send();
		end else if (pick < 75) begin
			case ($urandom_range(0, 9))
				0:       lat = 32'd0;
				1:       lat = $urandom;
				default: lat = $urandom_range(1, 400);
			endcase
			r = mk_req(rtt_trk_pkg::CMD_ACK,
				live_keys[$urandom_range(0, live_keys.size() - 1)],
				1'($urandom_range(0, 1)), 1'b0, flow_now + lat);
			flow_now = flow_now + $urandom_range(0, 20);
		end else if (pick < 82) begin
			r = mk_req(rtt_trk_pkg::CMD_ACK, $urandom, 1'($urandom_range(0, 1)), 1'b1,
				$urandom);
		end else if (pick < 90) begin
			r = mk_req(rtt_trk_pkg::CMD_ACK, $urandom, 1'($urandom_range(0, 1)), 1'b0,
				$urandom);
		end else if (pick < 95) begin
			r = last_send;
			r.now_ms = $urandom;
		end else begin
			r = mk_req(rtt_trk_pkg::CMD_SEND, $urandom, 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)), $urandom);
		end
		return r;
	endfunction

	// Offer one request, hold it until accepted, then log its expected result.
	// Valid is left high so a back-to-back request needs no extra edge.
	task automatic send_req(input rtt_trk_pkg::in_item_t req, input logic typed_in,
			input rtt_trk_pkg::out_item_t want);
		rtt_trk_pkg::out_item_t pred;
		int        gap;
		@(negedge clk);
		gap = (send_idle && $urandom_range(0, 5) == 0) ? $urandom_range(1, 5) : 0;
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		in_data  = req;
		do @(posedge clk); while (!in_ready);
		pred = predict_rtt(req);
		rtt_expect_q.push_back(typed_in ? want : pred);
	endtask

	// Hold off the sender until every result is back and the table scan of
	// the last request has surely finished.
	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (rtt_expect_q.size() != 0) @(posedge clk);
		repeat (SCAN_CYCLES) @(posedge clk);
	endtask

	task automatic write_seg_size(input logic [15:0] val);
		@(negedge clk);
		cfg_wr_en   = 1'b1;
		cfg_wr_data = val;
		@(negedge clk);
		cfg_wr_en   = 1'b0;
		seg_size    = val;
	endtask

	task automatic check_result(input rtt_trk_pkg::out_item_t got);
		rtt_trk_pkg::out_item_t exp;
		if (rtt_expect_q.size() == 0) begin
			if (err_count < REPORT_LIMIT)
				$display("unexpected result: status %0d rtt %0d", got.status, got.rtt_ms);
			err_count++;
		end else begin
			exp = rtt_expect_q.pop_front();
			if (got !== exp) begin
				if (err_count < REPORT_LIMIT)
					$display("mismatch: status %0d/%0d rtt %0d/%0d max %0d/%0d min %0d/%0d avg %0d/%0d",
						exp.status, got.status, exp.rtt_ms, got.rtt_ms,
						exp.rtt_max_ms, got.rtt_max_ms, exp.rtt_min_ms, got.rtt_min_ms,
						exp.rtt_avg_x8, got.rtt_avg_x8);
				err_count++;
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Clock, watchdog, result side
	// ------------------------------------------------------------------
	initial clk = 1'b0;
	always #(CLK_PERIOD / 2) clk = ~clk;

	// Bound the run; a hang anywhere ends here.
	always @(posedge clk) begin
		cycle_cnt = cycle_cnt + 1;
		if (cycle_cnt == RUN_LIMIT) begin
			$display("tcp_rtt_tracker test failed");
			$finish;
		end
	end

	// Drop out_ready in short random bursts while receiver idling is on.
	always @(negedge clk) begin
		if (stall_left > 0) begin
			out_ready  = 1'b0;
			stall_left = stall_left - 1;
		end else if (recv_idle && $urandom_range(0, 6) == 0) begin
			out_ready  = 1'b0;
			stall_left = $urandom_range(1, 5) - 1;
		end else begin
			out_ready = 1'b1;
		end
	end

	// Sample results at the rising edge, same as the block does.
	always @(posedge clk)
		if (arst_n && out_valid && out_ready)
			check_result(out_data);

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	initial begin
		logic [15:0] phase_seg;
		int          ph;
		int          r;

		arst_n      = 1'b0;
		in_valid    = 1'b0;
		in_data     = '0;
		out_ready   = 1'b0;
		cfg_wr_en   = 1'b0;
		cfg_wr_data = '0;
		err_count   = 0;
		cycle_cnt   = 0;
		stall_left  = 0;
		send_idle   = 1'b1;
		recv_idle   = 1'b1;
		seg_size    = rtt_trk_pkg::SEG_SIZE_RESET;
		hi_rtt      = '0;
		lo_rtt      = '0;
		avg_x8      = '0;
		for (r = 0; r < TBL_DEPTH; r++) begin
			tbl_live[r] = 1'b0;
			tbl_key[r]  = '0;
			tbl_sent[r] = '0;
		end
		flow_seq  = $urandom;
		flow_now  = $urandom;
		last_send = mk_req(rtt_trk_pkg::CMD_SEND, flow_seq, 1'b0, 1'b0, flow_now);

		// Directed part, segment size at its reset value of 1024.
		// FIN ack and stray ack on an empty table.
		add_row(mk_req(rtt_trk_pkg::CMD_ACK, 32'd0, 1'b0, 1'b1, 32'd0), 1'b1,
			mk_res(rtt_trk_pkg::ST_FIN, 32'd0, 32'd0, 32'd0, 35'd0));
		add_row(mk_req(rtt_trk_pkg::CMD_ACK, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'd0), 1'b1,
			mk_res(rtt_trk_pkg::ST_NOT_FOUND, 32'd0, 32'd0, 32'd0, 35'd0));
		// plain send expects 1024, then the same key again is a duplicate
		add_row(mk_req(rtt_trk_pkg::CMD_SEND, 32'd0, 1'b0, 1'b0, 32'd100), 1'b1,
			mk_res(rtt_trk_pkg::ST_RECORDED, 32'd0, 32'd0, 32'd0, 35'd0));
		add_row(mk_req(rtt_trk_pkg::CMD_SEND, 32'd0, 1'b0, 1'b0, 32'd999), 1'b1,
			mk_res(rtt_trk_pkg::ST_DUPLICATE, 32'd0, 32'd0, 32'd0, 35'd0));
		// SYN wraps to key 0; SYN with FIN still adds one
		add_row(mk_req(rtt_trk_pkg::CMD_SEND, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'd5), 1'b1,
			mk_res(rtt_trk_pkg::ST_RECORDED, 32'd0, 32'd0, 32'd0, 35'd0));
		add_row(mk_req(rtt_trk_pkg::CMD_SEND, 32'd10, 1'b1, 1'b1, 32'd6), 1'b1,
			mk_res(rtt_trk_pkg::ST_RECORDED, 32'd0, 32'd0, 32'd0, 35'd0));
		// FIN send expects seq + 1024 + 1 = 1125
		add_row(mk_req(rtt_trk_pkg::CMD_SEND, 32'd100, 1'b0, 1'b1, 32'd200), 1'b1,
			mk_res(rtt_trk_pkg::ST_RECORDED, 32'd0, 32'd0, 32'd0, 35'd0));
		// first measurement loads max, min and the average; purges 0, 11, 1024
		add_row(mk_req(rtt_trk_pkg::CMD_ACK, 32'd1024, 1'b0, 1'b0, 32'd150), 1'b1,
			mk_res(rtt_trk_pkg::ST_MEASURED, 32'd50, 32'd50, 32'd50, 35'd400));
		add_row(mk_req(rtt_trk_pkg::CMD_ACK, 32'd1125, 1'b0, 1'b1, 32'd0), 1'b1,
			mk_res(rtt_trk_pkg::ST_FIN, 32'd0, 32'd50, 32'd50, 35'd400));
		// zero rtt, then the same key is gone
		add_row(mk_req(rtt_trk_pkg::CMD_ACK, 32'd1125, 1'b0, 1'b0, 32'd200), 1'b0, '0);
		add_row(mk_req(rtt_trk_pkg::CMD_ACK, 32'd1125, 1'b0, 1'b0, 32'd300), 1'b0, '0);
		// key wraps past 2^32; the ack gives the largest possible rtt
		add_row(mk_req(rtt_trk_pkg::CMD_SEND, 32'hFFFF_FF00, 1'b0, 1'b0, 32'd1), 1'b0, '0);
		add_row(mk_req(rtt_trk_pkg::CMD_ACK, 32'h0000_0300, 1'b1, 1'b0, 32'd0), 1'b0, '0);
		// a key exactly 2^31 behind the ack counts as after and survives
		add_row(mk_req(rtt_trk_pkg::CMD_SEND, 32'h0000_0C00, 1'b0, 1'b0, 32'd7), 1'b0, '0);
		add_row(mk_req(rtt_trk_pkg::CMD_ACK, 32'h8000_1000, 1'b0, 1'b0, 32'd9), 1'b0, '0);
		add_row(mk_req(rtt_trk_pkg::CMD_ACK, 32'h0000_1000, 1'b0, 1'b0, 32'd9), 1'b0, '0);
		// FIN key wraps; an ack one short keeps it, then the hit wraps in time
		add_row(mk_req(rtt_trk_pkg::CMD_SEND, 32'hFFFF_FFFF, 1'b0, 1'b1, 32'hFFFF_FFFF),
			1'b0, '0);
		add_row(mk_req(rtt_trk_pkg::CMD_ACK, 32'h0000_03FF, 1'b0, 1'b0, 32'h0000_0005),
			1'b0, '0);
		add_row(mk_req(rtt_trk_pkg::CMD_ACK, 32'h0000_0400, 1'b0, 1'b0, 32'h0000_0010),
			1'b0, '0);

		// Hold reset, then release it away from the clock edge.
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (dir_rows[i])
			send_req(dir_rows[i].req, dir_rows[i].typed_in, dir_rows[i].want);

		// Random phases, each under its own segment size. The last phase runs
		// without idling on either side.
		for (ph = 0; ph < NUM_PHASES; ph++) begin
			case (ph)
				0:       phase_seg = 16'd1;
				1:       phase_seg = 16'hFFFF;
				2:       phase_seg = 16'd0;
				4:       phase_seg = rtt_trk_pkg::SEG_SIZE_RESET;
				6:       phase_seg = 16'($urandom_range(1, 64));
				default: phase_seg = 16'($urandom_range(1, 65535));
			endcase
			drain();
			write_seg_size(phase_seg);
			send_idle = (ph != NUM_PHASES - 1) && (ph % 3 != 2);
			recv_idle = (ph != NUM_PHASES - 1) && (ph % 3 != 1);
			// overfill the table so that sends come back full
			if (ph == 1 || ph == 4)
				repeat (TBL_DEPTH + 6)
					send_req(make_flow_send(), 1'b0, '0);
			repeat (PHASE_ITEMS)
				send_req(make_random_req(), 1'b0, '0);
		end

		// Wind down: wait for the last results, then wait on with no input to catch
		// any stray result.
		@(negedge clk);
		in_valid = 1'b0;
		while (rtt_expect_q.size() != 0) @(posedge clk);
		repeat (2 * SCAN_CYCLES) @(posedge clk);
		if (rtt_expect_q.size() != 0)
			err_count++;
		if (err_count == 0)
			$display("tcp_rtt_tracker test passed");
		else
			$display("tcp_rtt_tracker test failed");
		$finish;
	end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/rtt_trk_pkg.sv
rtl/rtt_trk_ram.sv
rtl/rtt_trk_ctrl.sv
rtl/rtt_trk_dp.sv
rtl/tcp_rtt_tracker.sv
sim/tcp_rtt_tracker_tb.sv
